FILE: src/ccbu_pkg.sv
// Shared types and constants for the conservative counting Bloom filter update block.
package ccbu_pkg;

   // Storage defaults
   localparam int DEF_COUNT_ADDR_BITS = 16;
   localparam int DEF_SEQ_ADDR_BITS   = 16;
   localparam int DEF_NUM_SEQ_HASH    = 8;

   // Fixed field widths
   localparam int MAX_SEQ_HASH = 8;
   localparam int HASH_W       = 32;
   localparam int CNT_W        = 4;
   localparam int SEL_W        = 3;
   localparam int TOTAL_W      = 32;
   localparam int THR_W        = 4;
   localparam int LEN_W        = 5;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 5;

   localparam logic [CNT_W-1:0]   CNT_MAX   = 4'd15;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'hFFFF_FFFF;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MIN_COUNT_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COUNT_LEN_LOG2      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SEQ_LEN_LOG2        = 2'd2;

   // Register reset values
   localparam logic [THR_W-1:0] RST_MIN_COUNT_THRESHOLD = 4'd2;
   localparam logic [LEN_W-1:0] RST_COUNT_LEN_LOG2      = 5'd16;
   localparam logic [LEN_W-1:0] RST_SEQ_LEN_LOG2        = 5'd16;

   // Transaction kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // Controller to datapath commands
   typedef struct packed {
      logic clear;         // zero one entry of every store, advance sweep
      logic capture;       // take the request payload
      logic read;          // read counters and valid bits
      logic write_first;   // first counter write, valid bits, valid count
      logic write_second;  // second counter write
      logic load_rsp;      // load the result register
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

FILE: src/ccbu_ctrl.sv
// Controller state machine for the conservative counting Bloom filter update block.
module ccbu_ctrl
   import ccbu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [5:0] {
      ST_CLEAR    = 6'b000001,
      ST_IDLE     = 6'b000010,
      ST_READ     = 6'b000100,
      ST_UPDATE_A = 6'b001000,
      ST_UPDATE_B = 6'b010000,
      ST_RESPOND  = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept, rsp_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   // Result register can take a new result when empty or being drained
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in    = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_UPDATE_A;
         end
         ST_UPDATE_A: begin
            cmd.write_first = 1'b1;
            state_in        = ST_UPDATE_B;
         end
         ST_UPDATE_B: begin
            cmd.write_second = 1'b1;
            state_in         = ST_RESPOND;
         end
         ST_RESPOND: begin
            if (rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: src/ccbu_datapath.sv
// Datapath: counter memories, valid-bit memories, minimum and update logic, result register.
module ccbu_datapath
   import ccbu_pkg::*;
#(
   parameter int COUNT_ADDR_BITS = DEF_COUNT_ADDR_BITS,
   parameter int SEQ_ADDR_BITS   = DEF_SEQ_ADDR_BITS,
   parameter int NUM_SEQ_HASH    = DEF_NUM_SEQ_HASH
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic [THR_W-1:0]   min_count_threshold,
   input  logic [LEN_W-1:0]   count_len_log2,
   input  logic [LEN_W-1:0]   seq_len_log2,
   input  logic               kind,
   input  logic [HASH_W-1:0]  hash [MAX_SEQ_HASH],
   input  logic [SEL_W-1:0]   vector_select,
   output logic               became_valid,
   output logic [TOTAL_W-1:0] valid_total,
   output logic               bit_value
);

   localparam int CLR_W   = (COUNT_ADDR_BITS > SEQ_ADDR_BITS) ? COUNT_ADDR_BITS
                                                              : SEQ_ADDR_BITS;
   localparam int C_DEPTH = 2 ** COUNT_ADDR_BITS;
   localparam int S_DEPTH = 2 ** SEQ_ADDR_BITS;

   function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                                input logic [1:0]       inc);
      logic [CNT_W:0] s;
      s = {1'b0, c} + {{(CNT_W-1){1'b0}}, inc};
      return (s > {1'b0, CNT_MAX}) ? CNT_MAX : s[CNT_W-1:0];
   endfunction

   // Clearing sweep
   logic [CLR_W-1:0] clr_ff, clr_in;

   // Captured transaction
   logic                       kind_ff;
   logic [SEL_W-1:0]           sel_ff;
   logic [COUNT_ADDR_BITS-1:0] caddr_ff [4];
   logic [SEQ_ADDR_BITS-1:0]   saddr_ff [NUM_SEQ_HASH];

   // Index masks
   logic [COUNT_ADDR_BITS-1:0] cmask;
   logic [SEQ_ADDR_BITS-1:0]   smask;

   // Counter read data
   logic [CNT_W-1:0] c0_ff, c1_ff, c2_ff, c3_ff;
   logic             vrd_ff [NUM_SEQ_HASH];
   logic [MAX_SEQ_HASH-1:0] vrd_pad;

   logic [TOTAL_W-1:0] count_ff, count_in;

   logic               rsp_became_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;
   logic               rsp_bit_ff;

   // Update decision
   logic [CNT_W-1:0] m01, m23, m;
   logic             do_upd, became;
   logic             hit0, hit1, hit2, hit3, same01, same23;
   logic             bit_sel;

   // Counter write ports
   logic                       fw_en, sw_en;
   logic [COUNT_ADDR_BITS-1:0] fw_addr, sw_addr;
   logic [CNT_W-1:0]           fw_data, sw_data;
   logic                       vw_en;

   logic [CNT_W-1:0] first_mem  [C_DEPTH];
   logic [CNT_W-1:0] second_mem [C_DEPTH];

   assign status.clear_last = &clr_ff;
   assign clr_in            = clr_ff + 1'b1;

   always_comb begin
      for (int i = 0; i < COUNT_ADDR_BITS; i++) begin
         cmask[i] = ({1'b0, 6'(i)} < {2'b00, count_len_log2});
      end
      for (int i = 0; i < SEQ_ADDR_BITS; i++) begin
         smask[i] = ({1'b0, 6'(i)} < {2'b00, seq_len_log2});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear) begin
         clr_ff <= clr_in;
      end
   end

   // Capture the masked addresses of the transaction
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= kind;
         sel_ff  <= vector_select;
         for (int i = 0; i < 4; i++) begin
            caddr_ff[i] <= hash[i][COUNT_ADDR_BITS-1:0] & cmask;
         end
         for (int h = 0; h < NUM_SEQ_HASH; h++) begin
            saddr_ff[h] <= hash[h][SEQ_ADDR_BITS-1:0] & smask;
         end
      end
   end

   // Minimum of the four counters and the conservative update decision
   always_comb begin
      m01    = (c1_ff < c0_ff) ? c1_ff : c0_ff;
      m23    = (c3_ff < c2_ff) ? c3_ff : c2_ff;
      m      = (m23 < m01) ? m23 : m01;
      do_upd = (kind_ff == KIND_INSERT) && (m < min_count_threshold);
      became = do_upd && (({1'b0, m} + 5'd1) == {1'b0, min_count_threshold});
      hit0   = (c0_ff == m);
      hit1   = (c1_ff == m);
      hit2   = (c2_ff == m);
      hit3   = (c3_ff == m);
      same01 = (caddr_ff[0] == caddr_ff[1]);
      same23 = (caddr_ff[2] == caddr_ff[3]);
   end

   // Counter write ports: first pass covers hash 0 and 2 (plus a repeated slot),
   // second pass covers hash 1 and 3 when they address a distinct slot
   always_comb begin
      fw_en   = 1'b0;
      sw_en   = 1'b0;
      fw_addr = caddr_ff[0];
      sw_addr = caddr_ff[2];
      fw_data = sat_add(c0_ff, {1'b0, hit0} + {1'b0, same01 && hit1});
      sw_data = sat_add(c2_ff, {1'b0, hit2} + {1'b0, same23 && hit3});
      if (cmd.clear) begin
         fw_en   = 1'b1;
         sw_en   = 1'b1;
         fw_addr = clr_ff[COUNT_ADDR_BITS-1:0];
         sw_addr = clr_ff[COUNT_ADDR_BITS-1:0];
         fw_data = '0;
         sw_data = '0;
      end else if (cmd.write_first) begin
         fw_en = do_upd;
         sw_en = do_upd;
      end else if (cmd.write_second) begin
         fw_en   = do_upd && !same01;
         sw_en   = do_upd && !same23;
         fw_addr = caddr_ff[1];
         sw_addr = caddr_ff[3];
         fw_data = sat_add(c1_ff, {1'b0, hit1});
         sw_data = sat_add(c3_ff, {1'b0, hit3});
      end
   end

   always_ff @(posedge clock) begin
      if (fw_en) begin
         first_mem[fw_addr] <= fw_data;
      end
      if (cmd.read) begin
         c0_ff <= first_mem[caddr_ff[0]];
         c1_ff <= first_mem[caddr_ff[1]];
      end
   end

   always_ff @(posedge clock) begin
      if (sw_en) begin
         second_mem[sw_addr] <= sw_data;
      end
      if (cmd.read) begin
         c2_ff <= second_mem[caddr_ff[2]];
         c3_ff <= second_mem[caddr_ff[3]];
      end
   end

   // Valid-bit vectors, one memory each; all are read at the hash 0 address
   assign vw_en = cmd.clear || (cmd.write_first && became);

   for (genvar h = 0; h < NUM_SEQ_HASH; h++) begin : g_vec
      logic                     vmem [S_DEPTH];
      logic [SEQ_ADDR_BITS-1:0] vw_addr;

      assign vw_addr = cmd.clear ? clr_ff[SEQ_ADDR_BITS-1:0] : saddr_ff[h];

      always_ff @(posedge clock) begin
         if (vw_en) begin
            vmem[vw_addr] <= !cmd.clear;
         end
         if (cmd.read) begin
            vrd_ff[h] <= vmem[saddr_ff[0]];
         end
      end
   end

   always_comb begin
      vrd_pad = '0;
      for (int h = 0; h < NUM_SEQ_HASH; h++) begin
         vrd_pad[h] = vrd_ff[h];
      end
      bit_sel = (kind_ff == KIND_READ) && ({1'b0, sel_ff} < 4'(NUM_SEQ_HASH))
                && vrd_pad[sel_ff];
   end

   // Saturating count of valid k-mers
   always_comb begin
      count_in = count_ff;
      if (cmd.write_first && became && (count_ff != TOTAL_MAX)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_became_ff <= became;
         rsp_total_ff  <= count_ff;
         rsp_bit_ff    <= bit_sel;
      end
   end

   assign became_valid = rsp_became_ff;
   assign valid_total  = rsp_total_ff;
   assign bit_value    = rsp_bit_ff;

endmodule

FILE: src/conservative_counting_bloom_update.sv
// Top level of the conservative-update counting Bloom filter block.
//
// Usage:
//   Each request transaction carries the eight precomputed hashes of one k-mer
//   (req_kind insert) or a valid-bit lookup (req_kind read: req_hash_0 is the
//   bit index, req_vector_select picks the vector). Every request produces
//   exactly one response transaction on the rsp_ channel, in request order.
//   A transaction moves when valid is high and stall is low on its channel.
//   Each request runs a read-modify-write sequence on the counter memories:
//   accept, one read of four counters, two write passes of one address per
//   counter memory each, then load of the response register, which waits
//   until that register is free; rsp_valid rises as it is loaded. The block
//   takes no new request until the current one has loaded its response.
//   A request may be accepted while the previous response still waits on a
//   stalled receiver; the block then holds the new result until the response
//   register is drained.
//   Reset: counters and valid bits are cleared by a sweep after reset over
//   2**max(COUNT_ADDR_BITS, SEQ_ADDR_BITS) entries, during which
//   req_stall stays high. Write csr_ registers only while the block is idle;
//   a write takes effect at the next edge.
module conservative_counting_bloom_update
   import ccbu_pkg::*;
#(
   parameter int COUNT_ADDR_BITS = DEF_COUNT_ADDR_BITS,
   parameter int SEQ_ADDR_BITS   = DEF_SEQ_ADDR_BITS,
   parameter int NUM_SEQ_HASH    = DEF_NUM_SEQ_HASH
) (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration write port
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // Request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_kind,
   input  logic [HASH_W-1:0]     req_hash_0,
   input  logic [HASH_W-1:0]     req_hash_1,
   input  logic [HASH_W-1:0]     req_hash_2,
   input  logic [HASH_W-1:0]     req_hash_3,
   input  logic [HASH_W-1:0]     req_hash_4,
   input  logic [HASH_W-1:0]     req_hash_5,
   input  logic [HASH_W-1:0]     req_hash_6,
   input  logic [HASH_W-1:0]     req_hash_7,
   input  logic [SEL_W-1:0]      req_vector_select,
   // Response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_became_valid,
   output logic [TOTAL_W-1:0]    rsp_valid_total,
   output logic                  rsp_bit_value
);

   // Configuration registers
   logic [THR_W-1:0] threshold_ff, threshold_in;
   logic [LEN_W-1:0] count_len_ff, count_len_in;
   logic [LEN_W-1:0] seq_len_ff, seq_len_in;

   logic [HASH_W-1:0] hash [MAX_SEQ_HASH];
   cmd_type           cmd;
   status_type        status;

   // Decode configuration writes; an index past the register list is dropped
   always_comb begin
      threshold_in = threshold_ff;
      count_len_in = count_len_ff;
      seq_len_in   = seq_len_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_MIN_COUNT_THRESHOLD: threshold_in = csr_wdata[THR_W-1:0];
            REG_COUNT_LEN_LOG2:      count_len_in = csr_wdata;
            REG_SEQ_LEN_LOG2:        seq_len_in   = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= RST_MIN_COUNT_THRESHOLD;
         count_len_ff <= RST_COUNT_LEN_LOG2;
         seq_len_ff   <= RST_SEQ_LEN_LOG2;
      end else begin
         threshold_ff <= threshold_in;
         count_len_ff <= count_len_in;
         seq_len_ff   <= seq_len_in;
      end
   end

   // Gather the hash ports into one array for the datapath
   assign hash[0] = req_hash_0;
   assign hash[1] = req_hash_1;
   assign hash[2] = req_hash_2;
   assign hash[3] = req_hash_3;
   assign hash[4] = req_hash_4;
   assign hash[5] = req_hash_5;
   assign hash[6] = req_hash_6;
   assign hash[7] = req_hash_7;

   ccbu_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ccbu_datapath #(
      .COUNT_ADDR_BITS (COUNT_ADDR_BITS),
      .SEQ_ADDR_BITS   (SEQ_ADDR_BITS),
      .NUM_SEQ_HASH    (NUM_SEQ_HASH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .min_count_threshold (threshold_ff),
      .count_len_log2      (count_len_ff),
      .seq_len_log2        (seq_len_ff),
      .kind                (req_kind),
      .hash                (hash),
      .vector_select       (req_vector_select),
      .became_valid        (rsp_became_valid),
      .valid_total         (rsp_valid_total),
      .bit_value           (rsp_bit_value)
   );

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the conservative-update counting Bloom filter block.
`timescale 1ns / 1ps

module tb;
   import ccbu_pkg::*;

   // Generous bound: the clearing sweep after reset covers 65536 entries, and
   // the rest of the run is a few hundred transactions.
   localparam int unsigned CYCLE_LIMIT  = 400_000;
   localparam int          DRAIN_LIMIT  = 5_000;
   localparam int          REPORT_LIMIT = 10;
   localparam int          IDLE_PCT     = 29;
   localparam int          HOLDOFF_LEN  = 300;

   typedef struct packed {
      logic                                kind;
      logic [MAX_SEQ_HASH-1:0][HASH_W-1:0] hash;
      logic [SEL_W-1:0]                    sel;
   } kmer_req_type;

   typedef struct packed {
      logic               became;
      logic [TOTAL_W-1:0] total;
      logic               bitv;
   } bloom_rsp_type;

   // DUT ports, all driven from time zero
   logic                  clock             = 1'b0;
   logic                  reset             = 1'b1;
   logic                  csr_write_en      = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index         = '0;
   logic [CSR_DATA_W-1:0] csr_wdata         = '0;
   logic                  req_valid         = 1'b0;
   logic                  req_stall;
   logic                  req_kind          = KIND_INSERT;
   logic [HASH_W-1:0]     req_hash_0        = '0;
   logic [HASH_W-1:0]     req_hash_1        = '0;
   logic [HASH_W-1:0]     req_hash_2        = '0;
   logic [HASH_W-1:0]     req_hash_3        = '0;
   logic [HASH_W-1:0]     req_hash_4        = '0;
   logic [HASH_W-1:0]     req_hash_5        = '0;
   logic [HASH_W-1:0]     req_hash_6        = '0;
   logic [HASH_W-1:0]     req_hash_7        = '0;
   logic [SEL_W-1:0]      req_vector_select = '0;
   logic                  rsp_valid;
   logic                  rsp_stall         = 1'b0;
   logic                  rsp_became_valid;
   logic [TOTAL_W-1:0]    rsp_valid_total;
   logic                  rsp_bit_value;

   // Shadow copy of the filter state and its registers
   bit [CNT_W-1:0]   first_cnt  [1 << DEF_COUNT_ADDR_BITS];
   bit [CNT_W-1:0]   second_cnt [1 << DEF_COUNT_ADDR_BITS];
   bit               valid_vec  [DEF_NUM_SEQ_HASH][1 << DEF_SEQ_ADDR_BITS];
   bit [TOTAL_W-1:0] valid_kmers   = '0;
   bit [THR_W-1:0]   cfg_threshold = RST_MIN_COUNT_THRESHOLD;
   bit [LEN_W-1:0]   cfg_count_len = RST_COUNT_LEN_LOG2;
   bit [LEN_W-1:0]   cfg_seq_len   = RST_SEQ_LEN_LOG2;

   // Responses still owed by the block, oldest first
   bloom_rsp_type expected_q [$];

   // Flow control knobs; written on a rising edge, read on a falling edge
   int          req_idle_pct = IDLE_PCT;
   int          rsp_idle_pct = IDLE_PCT;
   int          holdoff_len  = 0;
   int          holdoff_left = 0;

   int unsigned cycle_count    = 0;
   int          fail_count     = 0;
   int          items_accepted = 0;
   int          reads_accepted = 0;
   int          results_seen   = 0;
   int          became_seen    = 0;
   int          bits_seen      = 0;

   conservative_counting_bloom_update u_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_hash_0        (req_hash_0),
      .req_hash_1        (req_hash_1),
      .req_hash_2        (req_hash_2),
      .req_hash_3        (req_hash_3),
      .req_hash_4        (req_hash_4),
      .req_hash_5        (req_hash_5),
      .req_hash_6        (req_hash_6),
      .req_hash_7        (req_hash_7),
      .req_vector_select (req_vector_select),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_became_valid  (rsp_became_valid),
      .rsp_valid_total   (rsp_valid_total),
      .rsp_bit_value     (rsp_bit_value)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // Filter prediction
   // ------------------------------------------------------------------

   // Index mask for a configured width; widths beyond the storage clamp to it,
   // and a width of zero pins every index to entry 0.
   function automatic logic [31:0] len_mask(input logic [LEN_W-1:0] width, input int cap);
      int n;
      n = (width > cap) ? cap : width;
      return (32'h1 << n) - 32'h1;
   endfunction

   function automatic logic [CNT_W-1:0] bump_sat(input logic [CNT_W-1:0] c);
      return (c == CNT_MAX) ? c : c + 1'b1;
   endfunction

   // Apply one transaction to the shadow filter and return the response it owes.
   function automatic bloom_rsp_type predict_update(input kmer_req_type r);
      bloom_rsp_type                  res;
      logic [31:0]                    cmask;
      logic [31:0]                    smask;
      logic [DEF_COUNT_ADDR_BITS-1:0] a0, a1, a2, a3;
      logic [CNT_W-1:0]               c0, c1, c2, c3, low;
      res   = '0;
      cmask = len_mask(cfg_count_len, DEF_COUNT_ADDR_BITS);
      smask = len_mask(cfg_seq_len, DEF_SEQ_ADDR_BITS);
      if (r.kind == KIND_READ) begin
         // a vector past the configured count reads as zero
         if (r.sel < DEF_NUM_SEQ_HASH)
            res.bitv = valid_vec[r.sel][DEF_SEQ_ADDR_BITS'(r.hash[0] & smask)];
      end else begin
         a0  = DEF_COUNT_ADDR_BITS'(r.hash[0] & cmask);
         a1  = DEF_COUNT_ADDR_BITS'(r.hash[1] & cmask);
         a2  = DEF_COUNT_ADDR_BITS'(r.hash[2] & cmask);
         a3  = DEF_COUNT_ADDR_BITS'(r.hash[3] & cmask);
         c0  = first_cnt[a0];
         c1  = first_cnt[a1];
         c2  = second_cnt[a2];
         c3  = second_cnt[a3];
         low = c0;
         if (c1 < low) low = c1;
         if (c2 < low) low = c2;
         if (c3 < low) low = c3;
         // a zero threshold is never above the minimum: nothing moves
         if (low < cfg_threshold) begin
            if (low + 1 == cfg_threshold) begin
               res.became = 1'b1;
               if (valid_kmers != TOTAL_MAX)
                  valid_kmers = valid_kmers + 1'b1;
               for (int h = 0; h < DEF_NUM_SEQ_HASH; h++)
                  valid_vec[h][DEF_SEQ_ADDR_BITS'(r.hash[h] & smask)] = 1'b1;
            end
            // bump in sequence so a slot hit twice takes two increments
            if (c0 == low) first_cnt[a0]  = bump_sat(first_cnt[a0]);
            if (c1 == low) first_cnt[a1]  = bump_sat(first_cnt[a1]);
            if (c2 == low) second_cnt[a2] = bump_sat(second_cnt[a2]);
            if (c3 == low) second_cnt[a3] = bump_sat(second_cnt[a3]);
         end
      end
      res.total = valid_kmers;
      return res;
   endfunction

   task automatic note_failure(input string msg);
      fail_count++;
      if (fail_count <= REPORT_LIMIT)
         $display("ERROR @%0t: %s", $realtime, msg);
   endtask

   // ------------------------------------------------------------------
   // Monitor and scoreboard: sample both channels on the rising edge.
   // Check the response before predicting, so one process owns the order.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_and_predict
      bloom_rsp_type want;
      kmer_req_type  seen;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_q.size() == 0) begin
               note_failure($sformatf({"unexpected response became_valid=%0d ",
                  "valid_total=%0d bit_value=%0d"},
                  rsp_became_valid, rsp_valid_total, rsp_bit_value));
            end else begin
               want = expected_q.pop_front();
               if (rsp_became_valid !== want.became || rsp_valid_total !== want.total ||
                   rsp_bit_value !== want.bitv) begin
                  note_failure($sformatf({"response %0d mismatch: expected became_valid=%0d ",
                     "valid_total=%0d bit_value=%0d, got %0d %0d %0d"}, results_seen,
                     want.became, want.total, want.bitv,
                     rsp_became_valid, rsp_valid_total, rsp_bit_value));
               end
               if (rsp_became_valid === 1'b1) became_seen++;
               if (rsp_bit_value === 1'b1) bits_seen++;
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               REG_MIN_COUNT_THRESHOLD: cfg_threshold = csr_wdata[THR_W-1:0];
               REG_COUNT_LEN_LOG2:      cfg_count_len = csr_wdata[LEN_W-1:0];
               REG_SEQ_LEN_LOG2:        cfg_seq_len   = csr_wdata[LEN_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            seen.kind    = req_kind;
            seen.hash[0] = req_hash_0;
            seen.hash[1] = req_hash_1;
            seen.hash[2] = req_hash_2;
            seen.hash[3] = req_hash_3;
            seen.hash[4] = req_hash_4;
            seen.hash[5] = req_hash_5;
            seen.hash[6] = req_hash_6;
            seen.hash[7] = req_hash_7;
            seen.sel     = req_vector_select;
            expected_q.push_back(predict_update(seen));
            items_accepted++;
            if (req_kind == KIND_READ) reads_accepted++;
         end
      end
   end

   // Receiver: stall at random, or hold off for a full stretch when asked.
   always @(negedge clock) begin
      if (holdoff_len != 0) begin
         holdoff_left = holdoff_len;
         holdoff_len  = 0;
      end
      if (holdoff_left != 0) begin
         holdoff_left = holdoff_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d responses still owed",
            cycle_count, expected_q.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers. Every task starts and ends just after a falling edge.
   // ------------------------------------------------------------------

   function automatic kmer_req_type random_insert();
      kmer_req_type r;
      r.kind = KIND_INSERT;
      for (int h = 0; h < MAX_SEQ_HASH; h++)
         r.hash[h] = $urandom;
      r.sel = SEL_W'($urandom_range(7));
      return r;
   endfunction

   // Insert with evenly spaced hashes: base, base + stride, ...
   function automatic kmer_req_type kmer_insert(input logic [HASH_W-1:0] base,
                                                input logic [HASH_W-1:0] stride);
      kmer_req_type r;
      r.kind = KIND_INSERT;
      for (int h = 0; h < MAX_SEQ_HASH; h++)
         r.hash[h] = base + h * stride;
      r.sel = SEL_W'($urandom_range(7));
      return r;
   endfunction

   function automatic kmer_req_type bit_read(input logic [SEL_W-1:0] sel,
                                             input logic [HASH_W-1:0] index);
      kmer_req_type r;
      r         = random_insert();
      r.kind    = KIND_READ;
      r.sel     = sel;
      r.hash[0] = index;
      return r;
   endfunction

   // Offer one transaction and hold it until the block takes it.
   task automatic send_item(input kmer_req_type item);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_kind          = item.kind;
      req_hash_0        = item.hash[0];
      req_hash_1        = item.hash[1];
      req_hash_2        = item.hash[2];
      req_hash_3        = item.hash[3];
      req_hash_4        = item.hash[4];
      req_hash_5        = item.hash[5];
      req_hash_6        = item.hash[6];
      req_hash_7        = item.hash[7];
      req_vector_select = item.sel;
      req_valid         = 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering and wait until every owed response has come back.
   task automatic drain_results();
      req_valid = 1'b0;
      while (expected_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      csr_write_en = 1'b1;
      csr_index    = idx;
      csr_wdata    = value[CSR_DATA_W-1:0];
      @(negedge clock);
      csr_write_en = 1'b0;
   endtask

   task automatic set_filter(input int threshold, input int count_len, input int seq_len);
      write_reg(REG_MIN_COUNT_THRESHOLD, threshold);
      write_reg(REG_COUNT_LEN_LOG2, count_len);
      write_reg(REG_SEQ_LEN_LOG2, seq_len);
   endtask

   // Change the knobs on a rising edge so the receiver never races them.
   task automatic set_idling(input int req_pct, input int rsp_pct);
      @(posedge clock);
      req_idle_pct = req_pct;
      rsp_idle_pct = rsp_pct;
      @(negedge clock);
   endtask

   // Mostly repeated k-mers from a small pool so counters climb to the
   // threshold; the rest are fresh k-mers and lookups of pool bits and of random bits.
   task automatic random_burst(input int count, input int pool_size);
      kmer_req_type pool [$];
      kmer_req_type item;
      int           roll;
      int           pick;
      for (int i = 0; i < pool_size; i++)
         pool.push_back(random_insert());
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(pool_size - 1);
         if ($urandom_range(9) == 0)
            pool[pick] = random_insert();
         roll = $urandom_range(99);
         if (roll < 60) begin
            item = pool[pick];
         end else if (roll < 72) begin
            item = random_insert();
         end else if (roll < 90) begin
            item = bit_read(SEL_W'($urandom_range(7)), 0);
            item.hash[0] = pool[pick].hash[item.sel];
         end else begin
            item = bit_read(SEL_W'($urandom_range(7)), $urandom);
         end
         send_item(item);
      end
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Extremes of the hash fields, a slot hit twice, reaching the threshold
   // and reading back every vector, at the reset register values.
   task automatic test_directed_basics();
      kmer_req_type kmer_a;
      kmer_a = kmer_insert(32'hA5A5_0010, 32'h0001_0003);
      set_filter(2, 16, 16);
      send_item(kmer_insert(32'h0, 32'h0));
      send_item(kmer_insert(32'h0, 32'h0));
      send_item(bit_read(0, 32'h0));
      send_item(kmer_a);
      send_item(kmer_a);
      for (int s = 0; s < DEF_NUM_SEQ_HASH; s++)
         send_item(bit_read(SEL_W'(s), kmer_a.hash[s]));
      // upper bits fall outside the mask
      send_item(bit_read(3, kmer_a.hash[3] ^ 32'hFFFF_0000));
      send_item(kmer_insert(32'hFFFF_FFFF, 32'h0));
      send_item(bit_read(7, 32'hFFFF_FFFF));
      send_item(kmer_a);
      drain_results();
   endtask

   // A zero threshold freezes the filter; earlier valid bits still read back.
   task automatic test_zero_threshold();
      set_filter(0, 16, 16);
      random_burst(16, 2);
      send_item(bit_read(0, 32'hA5A5_0010));
      drain_results();
   endtask

   // Two counter slots per array: drive them to the top threshold and past.
   task automatic test_counter_saturation();
      set_filter(15, 1, 2);
      random_burst(60, 2);
      drain_results();
   endtask

   // Mask widths of zero, in range and beyond the storage.
   task automatic test_mask_widths();
      int thr_list  [6] = '{1, 3, 2, 1, 4, 15};
      int clen_list [6] = '{0, 17, 31, 1, 16, 5};
      int slen_list [6] = '{0, 31, 17, 16, 1, 3};
      for (int i = 0; i < 6; i++) begin
         set_filter(thr_list[i], clen_list[i], slen_list[i]);
         random_burst(12, 3);
         drain_results();
      end
   endtask

   // Hold off the receiver while the sender keeps offering, so the block
   // fills up and stalls its input.
   task automatic test_backpressure();
      set_filter(3, 6, 6);
      set_idling(0, 0);
      @(posedge clock);
      holdoff_len = HOLDOFF_LEN;
      @(negedge clock);
      random_burst(24, 4);
      drain_results();
      set_idling(IDLE_PCT, IDLE_PCT);
   endtask

   // Random traffic over several settings; one phase runs with no idling.
   task automatic test_random_traffic();
      int thr_list  [7] = '{2, 3, 1, 4, 15, 7, 0};
      int clen_list [7] = '{16, 8, 4, 10, 2, 12, 0};
      int slen_list [7] = '{16, 12, 4, 16, 3, 9, 0};
      for (int i = 0; i < 7; i++) begin
         // last phase picks its settings at random
         if (i == 6)
            set_filter($urandom_range(1, 15), $urandom_range(1, 16), $urandom_range(1, 16));
         else
            set_filter(thr_list[i], clen_list[i], slen_list[i]);
         if (i == 2) set_idling(0, 0);
         random_burst(38, 6);
         drain_results();
         if (i == 2) set_idling(IDLE_PCT, IDLE_PCT);
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      int waited;
      // hold reset, then release it on a falling edge
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // the block clears its stores first; send_item simply waits it out
      test_directed_basics();
      test_zero_threshold();
      test_counter_saturation();
      test_mask_widths();
      test_backpressure();
      test_random_traffic();

      // wait for stragglers, then give extra responses time to show up
      req_valid = 1'b0;
      waited = 0;
      while (expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (20) @(negedge clock);
      if (expected_q.size() != 0)
         note_failure($sformatf("%0d responses never arrived", expected_q.size()));

      $display("Covered %0d transactions (%0d bit reads), %0d k-mers became valid,",
         items_accepted, reads_accepted, became_seen);
      $display("%0d set bits read back, thresholds 0..15, mask widths 0..31, %0d failures",
         bits_seen, fail_count);
      if (fail_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

FILE: sim.f
src/ccbu_pkg.sv
src/ccbu_ctrl.sv
src/ccbu_datapath.sv
src/conservative_counting_bloom_update.sv
tb/sv/tb.sv
